// File: sv/block_interval_set_assert.svh
// ----------------------------------------------------------------------------
// block_interval_set_assert.svh
// Assertion macros used by the interval set top level.
// ----------------------------------------------------------------------------
`ifndef BLOCK_INTERVAL_SET_ASSERT_SVH
`define BLOCK_INTERVAL_SET_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BIS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("interval set check failed");

// next-cycle implication, checked outside reset
`define BIS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("interval set check failed");

`endif

// File: sv/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Types and codes shared by the interval set cells and the top level.
// ----------------------------------------------------------------------------
package bis_pkg;

	// request kinds
	typedef enum logic [1:0] {
		K_ADD    = 2'd0,
		K_REMOVE = 2'd1,
		K_QUERY  = 2'd2,
		K_CLEAR  = 2'd3
	} kind_e_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_COMPACT,
		ST_INSERT,
		ST_FIN
	} state_t;

	// per-cell operation broadcast by the sequencer
	typedef enum logic [2:0] {
		C_HOLD,
		C_MARK,
		C_TRIM,
		C_SPLIT,
		C_COMPACT,
		C_INSERT
	} cell_op_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] range_start;
		logic [15:0] range_end;
	} bis_in_t;

	typedef struct packed {
		logic        ok;
		logic        changed;
		logic        overlaps;
		logic [16:0] block_count;
		logic [6:0]  segment_count;
	} bis_out_t;

	// one stored interval
	typedef struct packed {
		logic [15:0] lo;
		logic [15:0] hi;
	} cell_ent_t;

	// command broadcast to every cell
	typedef struct packed {
		cell_op_t    op;
		logic [15:0] s;
		logic [15:0] e;
		logic [15:0] key;
	} cell_cmd_t;

	// per-cell status toward the sequencer
	typedef struct packed {
		logic contained;
		logic touch;
		logic overlap;
		logic split;
		logic ltrim;
		logic rtrim;
		logic first_dead;
		logic dead;
	} cell_flag_t;

endpackage

// File: sv/bis_cell.sv
// ----------------------------------------------------------------------------
// bis_cell
// One slot of the sorted interval row: compares against the request and
// trims, splits, marks, shifts left or shifts right with its neighbors.
// ----------------------------------------------------------------------------
module bis_cell import bis_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_cmd_t     cmd,
	input  logic [CW-1:0] count,
	input  cell_ent_t     ent_left,
	input  logic          ge_left,
	input  cell_ent_t     ent_right,
	input  logic          dead_right,
	input  logic          carry_in,
	output cell_ent_t     ent,
	output logic          ge,
	output logic          carry_out,
	output logic [16:0]   span,
	output cell_flag_t    flags
);

	cell_ent_t ent_q;
	logic      dead_q;
	logic      valid;
	logic      carry;
	logic [16:0] lo_x, hi_x, s_x, e_x;

	// local compares against the request
	always_comb begin
		valid = (CW'(IDX) < count);
		lo_x  = {1'b0, ent_q.lo};
		hi_x  = {1'b0, ent_q.hi};
		s_x   = {1'b0, cmd.s};
		e_x   = {1'b0, cmd.e};
		carry = carry_in | dead_q;
		flags.contained  = valid && (ent_q.lo <= cmd.s) && (ent_q.hi >= cmd.e);
		flags.touch      = valid && (hi_x + 17'd1 >= s_x) && (lo_x <= e_x + 17'd1);
		flags.overlap    = valid && (ent_q.lo <= cmd.e) && (ent_q.hi >= cmd.s);
		flags.split      = valid && (ent_q.lo < cmd.s) && (ent_q.hi > cmd.e);
		flags.ltrim      = flags.overlap && (ent_q.lo < cmd.s) && (ent_q.hi <= cmd.e);
		flags.rtrim      = flags.overlap && (ent_q.hi > cmd.e) && (ent_q.lo >= cmd.s);
		flags.first_dead = dead_q && !carry_in;
		flags.dead       = dead_q;
		ge        = !valid || (ent_q.lo >= cmd.key);
		carry_out = carry;
		ent       = ent_q;
		span      = hi_x - lo_x + 17'd1;
	end

	// dead mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q <= 1'b0;
		end else begin
			case (cmd.op)
				C_MARK:    dead_q <= flags.touch;
				C_TRIM:    dead_q <= flags.overlap && (ent_q.lo >= cmd.s) && (ent_q.hi <= cmd.e);
				C_COMPACT: if (carry) dead_q <= dead_right;
				default:   dead_q <= dead_q;
			endcase
		end
	end

	// interval payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			C_TRIM: begin
				if (flags.ltrim) ent_q.hi <= cmd.s - 16'd1;
				if (flags.rtrim) ent_q.lo <= cmd.e + 16'd1;
			end
			C_SPLIT: if (flags.split) ent_q.hi <= cmd.s - 16'd1;
			C_COMPACT: if (carry) ent_q <= ent_right;
			C_INSERT: begin
				if (ge && ge_left) ent_q <= ent_left;
				else if (ge) ent_q <= '{lo: cmd.key, hi: cmd.e};
			end
			default: ent_q <= ent_q;
		endcase
	end

endmodule

// File: sv/block_interval_set.sv
// ----------------------------------------------------------------------------
// block_interval_set
// Sorted set of disjoint block intervals kept in a row of cells.
// ----------------------------------------------------------------------------
// One request is in work at a time. A query, a clear, a rejected request or
// an add already covered passes through accept, evaluate and finish. A
// remove or a merging add also compacts the row, which drops one stored
// interval per cycle until no dead cell is left; an add or split that places
// a new entry shifts the row right in an insert step. A result waits in an
// output register while the next request is taken.
module block_interval_set import bis_pkg::*; #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  bis_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output bis_out_t out_data,
	input  logic     cfg_we,
	input  logic [6:0] cfg_wdata
);

	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int LW = (CW > 7) ? CW : 7;

	state_t state_q, state_d;
	logic [1:0]  kind_q;
	logic [15:0] s_q, e_q;
	logic [CW-1:0] count_q, count_d;
	logic [16:0] cov_q, cov_d;
	logic [6:0]  lim_q;
	logic ok_q, ok_d, chg_q, chg_d, ovl_q, ovl_d;
	logic [15:0] ins_lo_q, ins_lo_d, ins_hi_q, ins_hi_d;
	logic ins_add_q, ins_add_d, do_ins_q, do_ins_d;
	logic out_valid_q;
	bis_out_t out_q;
	cell_cmd_t cmd;

	cell_ent_t  ent   [MAX_SEGMENTS];
	logic       ge    [MAX_SEGMENTS];
	logic       carry [MAX_SEGMENTS];
	logic [16:0] span [MAX_SEGMENTS];
	cell_flag_t flags [MAX_SEGMENTS];

	logic any_cont, any_touch, any_ovl, any_split, any_dead;
	logic [15:0] lo_first, hi_last, split_hi, ltrim_hi, rtrim_lo;
	logic any_ltrim, any_rtrim;
	logic [16:0] pop_span, req_span, ins_span, lrm, rrm;
	logic [LW-1:0] lim_eff;
	logic full, bad, fin_load;
	logic [15:0] ns, ne;

	// cell row
	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		cell_ent_t lft, rgt;
		logic      ge_l, dead_r, cin;
		if (i == 0) begin : g_first
			assign lft  = '0;
			assign ge_l = 1'b0;
			assign cin  = 1'b0;
		end else begin : g_mid
			assign lft  = ent[i-1];
			assign ge_l = ge[i-1];
			assign cin  = carry[i-1];
		end
		if (i == MAX_SEGMENTS - 1) begin : g_last
			assign rgt    = '0;
			assign dead_r = 1'b0;
		end else begin : g_inner
			assign rgt    = ent[i+1];
			assign dead_r = flags[i+1].dead;
		end
		bis_cell #(.IDX(i), .CW(CW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.count      (count_q),
			.ent_left   (lft),
			.ge_left    (ge_l),
			.ent_right  (rgt),
			.dead_right (dead_r),
			.carry_in   (cin),
			.ent        (ent[i]),
			.ge         (ge[i]),
			.carry_out  (carry[i]),
			.span       (span[i]),
			.flags      (flags[i])
		);
	end

	// reductions over the row, one-hot picks
	always_comb begin
		any_cont = 1'b0; any_touch = 1'b0; any_ovl = 1'b0; any_split = 1'b0;
		any_dead = 1'b0; any_ltrim = 1'b0; any_rtrim = 1'b0;
		lo_first = '0; hi_last = '0; split_hi = '0; ltrim_hi = '0; rtrim_lo = '0;
		pop_span = '0;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			any_cont  |= flags[i].contained;
			any_touch |= flags[i].touch;
			any_ovl   |= flags[i].overlap;
			any_split |= flags[i].split;
			any_dead  |= flags[i].dead;
			any_ltrim |= flags[i].ltrim;
			any_rtrim |= flags[i].rtrim;
			if (flags[i].touch && (i == 0 || !flags[(i == 0) ? 0 : i-1].touch))
				lo_first |= ent[i].lo;
			if (flags[i].touch &&
			    (i == MAX_SEGMENTS - 1 || !flags[(i == MAX_SEGMENTS - 1) ? i : i+1].touch))
				hi_last |= ent[i].hi;
			if (flags[i].split) split_hi |= ent[i].hi;
			if (flags[i].ltrim) ltrim_hi |= ent[i].hi;
			if (flags[i].rtrim) rtrim_lo |= ent[i].lo;
			if (flags[i].first_dead) pop_span |= span[i];
		end
	end

	// request-derived values
	always_comb begin
		lim_eff  = (lim_q == 7'd0) ? LW'(1) : LW'(lim_q);
		if (lim_eff > LW'(MAX_SEGMENTS)) lim_eff = LW'(MAX_SEGMENTS);
		full     = LW'(count_q) >= lim_eff;
		bad      = s_q > e_q;
		req_span = {1'b0, e_q} - {1'b0, s_q} + 17'd1;
		ins_span = {1'b0, ins_hi_q} - {1'b0, ins_lo_q} + 17'd1;
		lrm      = any_ltrim ? ({1'b0, ltrim_hi} - {1'b0, s_q} + 17'd1) : 17'd0;
		rrm      = any_rtrim ? ({1'b0, e_q} - {1'b0, rtrim_lo} + 17'd1) : 17'd0;
		ns       = (lo_first < s_q) ? lo_first : s_q;
		ne       = (hi_last > e_q) ? hi_last : e_q;
		fin_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	// sequencer next state and row command
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		cov_d     = cov_q;
		ok_d      = ok_q;
		chg_d     = chg_q;
		ovl_d     = ovl_q;
		ins_lo_d  = ins_lo_q;
		ins_hi_d  = ins_hi_q;
		ins_add_d = ins_add_q;
		do_ins_d  = do_ins_q;
		cmd.op    = C_HOLD;
		cmd.s     = s_q;
		cmd.e     = (state_q == ST_INSERT) ? ins_hi_q : e_q;
		cmd.key   = ins_lo_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				ok_d     = 1'b1;
				chg_d    = 1'b0;
				ovl_d    = 1'b0;
				do_ins_d = 1'b0;
				state_d  = ST_FIN;
				if (kind_q == K_CLEAR) begin
					chg_d   = (count_q != '0);
					count_d = '0;
					cov_d   = '0;
				end else if (bad) begin
					ok_d = 1'b0;
				end else begin
					case (kind_q)
						K_ADD: begin
							if (!any_cont) begin
								chg_d = 1'b1;
								if (any_touch) begin
									cmd.op    = C_MARK;
									ins_lo_d  = ns;
									ins_hi_d  = ne;
									ins_add_d = 1'b1;
									do_ins_d  = 1'b1;
									state_d   = ST_COMPACT;
								end else if (full) begin
									ok_d = 1'b0;
								end else begin
									ins_lo_d  = s_q;
									ins_hi_d  = e_q;
									ins_add_d = 1'b1;
									state_d   = ST_INSERT;
								end
							end
						end
						K_REMOVE: begin
							if (any_split) begin
								if (full) begin
									ok_d = 1'b0;
								end else begin
									cmd.op    = C_SPLIT;
									chg_d     = 1'b1;
									cov_d     = cov_q - req_span;
									ins_lo_d  = e_q + 16'd1;
									ins_hi_d  = split_hi;
									ins_add_d = 1'b0;
									state_d   = ST_INSERT;
								end
							end else begin
								cmd.op  = C_TRIM;
								chg_d   = any_ovl;
								cov_d   = cov_q - lrm - rrm;
								state_d = ST_COMPACT;
							end
						end
						K_QUERY: ovl_d = any_ovl;
						default: ok_d = 1'b1;
					endcase
				end
			end
			ST_COMPACT: begin
				cmd.op = C_COMPACT;
				if (any_dead) begin
					count_d = count_q - CW'(1);
					cov_d   = cov_q - pop_span;
				end else begin
					state_d = do_ins_q ? ST_INSERT : ST_FIN;
				end
			end
			ST_INSERT: begin
				cmd.op  = C_INSERT;
				count_d = count_q + CW'(1);
				if (ins_add_q) cov_d = cov_q + ins_span;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (fin_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cov_q       <= '0;
			lim_q       <= 7'd64;
			do_ins_q    <= 1'b0;
			ins_add_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			cov_q     <= cov_d;
			do_ins_q  <= do_ins_d;
			ins_add_q <= ins_add_d;
			if (cfg_we) lim_q <= cfg_wdata;
			if (fin_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= in_data.kind;
			s_q    <= in_data.range_start;
			e_q    <= in_data.range_end;
		end
		ok_q     <= ok_d;
		chg_q    <= chg_d;
		ovl_q    <= ovl_d;
		ins_lo_q <= ins_lo_d;
		ins_hi_q <= ins_hi_d;
		if (fin_load) begin
			out_q.ok            <= ok_q;
			out_q.changed       <= chg_q;
			out_q.overlaps      <= ovl_q;
			out_q.block_count   <= cov_q;
			out_q.segment_count <= 7'(count_q);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`include "block_interval_set_assert.svh"

	`BIS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_SEGMENTS))
	`BIS_ASSERT_NEXT(a_compact_drop, (state_q == ST_COMPACT) && any_dead, count_q == $past(count_q) - CW'(1))
	`BIS_ASSERT_NEXT(a_insert_grow, state_q == ST_INSERT, count_q == $past(count_q) + CW'(1))

endmodule

// File: tb/block_interval_set_tb.sv
// ----------------------------------------------------------------------------
// block_interval_set_tb
// Self-checking bench for the block interval set.
// ----------------------------------------------------------------------------
// Requests go in on a valid/ready channel and each produces one response. A
// scoreboard class keeps its own sorted interval table, predicts each
// response when a request is accepted and compares responses in order. The
// run goes through directed cases, then random sequences under several limit
// settings and idling mixes, with a long receiver hold-off and a full drain.
module block_interval_set_tb;
	import bis_pkg::*;

	localparam int MAX_SEG = 64;
	localparam int IDLE_LIMIT = 20000;

	// scoreboard: interval table predictor and expected response queue
	class interval_scoreboard;
		logic [15:0] lo_q[$];
		logic [15:0] hi_q[$];
		int unsigned covered;
		int unsigned limit_reg;
		bis_out_t pending[$];
		int errors;

		function new();
			limit_reg = 64;
			covered = 0;
			errors = 0;
		endfunction

		function int unsigned cap();
			if (limit_reg < 1) return 1;
			if (limit_reg > MAX_SEG) return MAX_SEG;
			return limit_reg;
		endfunction

		function void add_range(int unsigned s, int unsigned e, ref bit ok, ref bit chg);
			int unsigned ns, ne, pos;
			int first, last;
			pos = 0;
			ns = s;
			ne = e;
			first = -1;
			last = -1;
			foreach (lo_q[i])
				if (lo_q[i] <= s && hi_q[i] >= e) begin
					ok = 1;
					chg = 0;
					return;
				end
			chg = 1;
			foreach (lo_q[i]) begin
				if (lo_q[i] < s) pos = i + 1;
				if (hi_q[i] + 1 >= s && lo_q[i] <= e + 1) begin
					if (first < 0) first = i;
					last = i;
					if (lo_q[i] < ns) ns = lo_q[i];
					if (hi_q[i] > ne) ne = hi_q[i];
				end
			end
			if (first >= 0) begin
				for (int k = last; k >= first; k--) begin
					covered -= hi_q[k] - lo_q[k] + 1;
					lo_q.delete(k);
					hi_q.delete(k);
				end
				lo_q.insert(first, ns[15:0]);
				hi_q.insert(first, ne[15:0]);
				covered += ne - ns + 1;
				ok = 1;
				return;
			end
			if (lo_q.size() >= cap()) begin
				ok = 0;
				return;
			end
			lo_q.insert(pos, s[15:0]);
			hi_q.insert(pos, e[15:0]);
			covered += e - s + 1;
			ok = 1;
		endfunction

		function void remove_range(int unsigned s, int unsigned e, ref bit ok, ref bit chg);
			logic [15:0] nlo[$];
			logic [15:0] nhi[$];
			int unsigned a, b;
			foreach (lo_q[i])
				if (lo_q[i] < s && hi_q[i] > e) begin
					if (lo_q.size() >= cap()) begin
						ok = 0;
						chg = 0;
						return;
					end
					b = hi_q[i];
					hi_q[i] = 16'(s - 1);
					lo_q.insert(i + 1, 16'(e + 1));
					hi_q.insert(i + 1, b[15:0]);
					covered -= e - s + 1;
					ok = 1;
					chg = 1;
					return;
				end
			chg = 0;
			foreach (lo_q[i]) begin
				a = lo_q[i];
				b = hi_q[i];
				if (b < s || a > e) begin
					nlo.insert(nlo.size(), a[15:0]);
					nhi.insert(nhi.size(), b[15:0]);
					continue;
				end
				chg = 1;
				covered -= b - a + 1;
				if (a >= s && b <= e) continue;
				if (a < s) b = s - 1;
				else a = e + 1;
				covered += b - a + 1;
				nlo.insert(nlo.size(), a[15:0]);
				nhi.insert(nhi.size(), b[15:0]);
			end
			lo_q = nlo;
			hi_q = nhi;
			ok = 1;
		endfunction

		// predict the response of an accepted request
		function void note_request(bis_in_t req);
			bis_out_t r;
			bit ok, chg, ovl;
			ok = 0;
			chg = 0;
			ovl = 0;
			if (req.kind == K_CLEAR) begin
				chg = lo_q.size() != 0;
				lo_q.delete();
				hi_q.delete();
				covered = 0;
				ok = 1;
			end else if (req.range_start > req.range_end) begin
				ok = 0;
			end else if (req.kind == K_ADD) begin
				add_range(req.range_start, req.range_end, ok, chg);
			end else if (req.kind == K_REMOVE) begin
				remove_range(req.range_start, req.range_end, ok, chg);
			end else begin
				foreach (lo_q[i])
					if (lo_q[i] <= req.range_end && hi_q[i] >= req.range_start) ovl = 1;
				ok = 1;
			end
			r.ok = ok;
			r.changed = chg;
			r.overlaps = ovl;
			r.block_count = covered[16:0];
			r.segment_count = 7'(lo_q.size());
			pending.insert(pending.size(), r);
		endfunction

		task report(string what, int unsigned got, int unsigned want);
			$display("mismatch %s: got %0d want %0d", what, got, want);
			errors++;
		endtask

		// compare a response with the oldest prediction
		task check_response(bis_out_t got);
			bis_out_t want;
			if (pending.size() == 0) begin
				report("response with nothing pending", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.ok !== want.ok) report("ok", got.ok, want.ok);
			if (got.changed !== want.changed) report("changed", got.changed, want.changed);
			if (got.overlaps !== want.overlaps) report("overlaps", got.overlaps, want.overlaps);
			if (got.block_count !== want.block_count)
				report("block_count", got.block_count, want.block_count);
			if (got.segment_count !== want.segment_count)
				report("segment_count", got.segment_count, want.segment_count);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	bis_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	bis_out_t out_data;
	logic cfg_we = 0;
	logic [6:0] cfg_wdata = '0;

	interval_scoreboard board = new();
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_off = 0;
	int idle_cycles = 0;

	block_interval_set #(.MAX_SEGMENTS(MAX_SEG)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// receiver: random stall, optional long hold-off, check on accept
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_response(out_data);
		out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
	end

	// watchdog on cycles without any accepted request or response
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// one request; valid drops on the accepting edge and rises no earlier
	// than the next edge
	task automatic send_request(logic [1:0] kind, logic [15:0] s, logic [15:0] e);
		@(posedge clk);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		in_data <= '{kind: kind, range_start: s, range_end: e};
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		board.note_request('{kind: kind, range_start: s, range_end: e});
		in_valid <= 0;
	endtask

	// let every pending response drain, then the block settle
	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (MAX_SEG + 10) @(posedge clk);
	endtask

	task automatic set_limit(int unsigned v);
		drain();
		cfg_wdata <= v[6:0];
		cfg_we <= 1;
		@(posedge clk);
		cfg_we <= 0;
		board.limit_reg = v;
	endtask

	// random request inside a window so intervals collide often
	task automatic random_request(int unsigned span_max);
		logic [15:0] s, e, base;
		logic [1:0] kind;
		int unsigned p;
		p = $urandom_range(99);
		if (p < 45) kind = K_ADD;
		else if (p < 80) kind = K_REMOVE;
		else if (p < 97) kind = K_QUERY;
		else kind = K_CLEAR;
		if ($urandom_range(9) == 0) begin
			s = 16'($urandom);
			e = 16'($urandom);
		end else begin
			base = ($urandom_range(3) == 0) ? 16'hff00 : 16'h0000;
			if ($urandom_range(1)) base = 16'($urandom);
			s = 16'(base + $urandom_range(span_max));
			e = 16'(s + $urandom_range(span_max / 4));
			if (e < s) e = 16'hffff;
		end
		send_request(kind, s, e);
	endtask

	task automatic random_phase(int n, int span_max);
		repeat (n) random_request(span_max);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every kind and corner cases
		send_request(K_QUERY, 16'd0, 16'hffff);
		send_request(K_REMOVE, 16'd5, 16'd9);
		send_request(K_ADD, 16'd9, 16'd5);
		send_request(K_REMOVE, 16'hffff, 16'd0);
		send_request(K_QUERY, 16'd7, 16'd6);
		send_request(K_ADD, 16'd0, 16'hffff);
		send_request(K_ADD, 16'd100, 16'd200);
		send_request(K_REMOVE, 16'd100, 16'd200);
		send_request(K_REMOVE, 16'd0, 16'd0);
		send_request(K_REMOVE, 16'hffff, 16'hffff);
		send_request(K_ADD, 16'd0, 16'd0);
		send_request(K_ADD, 16'hffff, 16'hffff);
		send_request(K_QUERY, 16'd1, 16'hfffe);
		send_request(K_CLEAR, 16'hffff, 16'hffff);
		send_request(K_CLEAR, 16'd0, 16'd0);
		send_request(K_ADD, 16'd10, 16'd20);
		send_request(K_ADD, 16'd30, 16'd40);
		send_request(K_ADD, 16'd21, 16'd29);
		send_request(K_REMOVE, 16'd15, 16'd35);
		set_limit(2);
		send_request(K_ADD, 16'd100, 16'd110);
		send_request(K_REMOVE, 16'd12, 16'd13);
		send_request(K_ADD, 16'd500, 16'd500);
		set_limit(0);
		send_request(K_ADD, 16'd600, 16'd601);
		set_limit(127);
		send_request(K_CLEAR, 16'd0, 16'd0);

		// random phases across limits and idling mixes
		send_idle = 20;
		recv_idle = 86;
		random_phase(200, 400);
		set_limit(1);
		random_phase(100, 200);
		send_idle = 86;
		recv_idle = 20;
		set_limit(4);
		random_phase(150, 300);
		set_limit(64);
		random_phase(250, 2000);

		// long hold-off while the sender keeps offering
		send_idle = 0;
		recv_idle = 0;
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			random_phase(30, 400);
		join
		drain();
		set_limit(64);
		random_phase(300, 3000);
		set_limit(17);
		random_phase(250, 500);

		drain();
		if (board.errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

// File: sim.f
+incdir+sv
sv/bis_pkg.sv
sv/bis_cell.sv
sv/block_interval_set.sv
tb/block_interval_set_tb.sv
